@@ rtl/fbpa_pkg.sv @@
// shared types, codes and constants of the fixed block pool allocator
`default_nettype none

package fbpa_pkg;

  localparam int POOL_BLOCKS_DEF = 256;
  localparam int INDEX_LIMIT     = 256;

  localparam int MODE_W   = 2;
  localparam int IDX_W    = 8;
  localparam int STATUS_W = 2;
  localparam int OFS_W    = 24;
  localparam int LINK_W   = 9;
  localparam int COUNT_W  = 9;
  localparam int SIZE_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [LINK_W-1:0]  NULL_LINK   = 9'h100;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 16'd64;

  typedef enum logic [MODE_W-1:0] {
    MODE_CREATE = 2'd0,
    MODE_RESIZE = 2'd1,
    MODE_ALLOC  = 2'd2,
    MODE_FREE   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_ALLOC = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_COUNT = 1'b0,
    REG_BLOCK_SIZE  = 1'b1
  } cfg_reg_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic walk;
    logic finish;
  } fbpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_last;
    logic slot_free;
  } fbpa_sts_t;

endpackage

`default_nettype wire

@@ rtl/fbpa_if.sv @@
// valid/ready channel interfaces for request and result beats
`default_nettype none

interface fbpa_in_if import fbpa_pkg::*; ();
  logic             valid;
  logic             ready;
  mode_t            mode;
  logic [IDX_W-1:0] block_index;
  logic             block_present;

  modport source (output valid, mode, block_index, block_present, input ready);
  modport sink   (input valid, mode, block_index, block_present, output ready);
endinterface

interface fbpa_out_if import fbpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    block_index_res;
  logic [OFS_W-1:0]    byte_offset;

  modport source (output valid, status, block_index_res, byte_offset, input ready);
  modport sink   (input valid, status, block_index_res, byte_offset, output ready);
endinterface

`default_nettype wire

@@ rtl/fbpa_ctrl.sv @@
// controller state machine: accept, chain walk, result hand-off
`default_nettype none

module fbpa_ctrl import fbpa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire mode_t     in_mode,
  output logic           in_ready,
  output fbpa_cmd_t      cmd,
  input  wire fbpa_sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESP
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_mode == MODE_CREATE || in_mode == MODE_RESIZE) begin
            state_nxt = ST_WALK;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts.slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/fbpa_dpath.sv @@
// datapath: config registers, free head, link memory, offset multiply, result register
`default_nettype none

module fbpa_dpath import fbpa_pkg::*; #(
  parameter int POOL_BLOCKS = POOL_BLOCKS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire mode_t                 in_mode,
  input  wire logic [IDX_W-1:0]      in_block_index,
  input  wire logic                  in_block_present,
  input  wire fbpa_cmd_t             cmd,
  output fbpa_sts_t                  sts,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic [IDX_W-1:0]           out_block_index_res,
  output logic [OFS_W-1:0]           out_byte_offset
);

  localparam int EFF = (POOL_BLOCKS < INDEX_LIMIT) ? POOL_BLOCKS : INDEX_LIMIT;
  localparam int AW  = $clog2(EFF);

  logic [LINK_W-1:0]  link_mem [EFF];
  logic [COUNT_W-1:0] count_r;
  logic [SIZE_W-1:0]  size_r;
  logic [LINK_W-1:0]  head_r;
  logic [LINK_W-1:0]  rd_r;
  mode_t              mode_r;
  logic [AW-1:0]      cnt_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [IDX_W-1:0]    index_r;
  logic [OFS_W-1:0]    offset_r;

  logic [COUNT_W-1:0] n_eff;
  logic [AW-1:0]      last_idx;
  logic               empty;
  logic               free_ok;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [LINK_W-1:0]  wr_data;
  logic [OFS_W-1:0]   product;

  // count zero still formats block 0, count above the pool saturates
  always_comb begin
    if (count_r == '0) begin
      n_eff = COUNT_W'(1);
    end else if (count_r > COUNT_W'(EFF)) begin
      n_eff = COUNT_W'(EFF);
    end else begin
      n_eff = count_r;
    end
  end

  assign last_idx = AW'(n_eff - COUNT_W'(1));
  assign empty    = head_r >= LINK_W'(EFF);
  assign free_ok  = in_block_present && ({1'b0, in_block_index} < LINK_W'(EFF));
  assign product  = OFS_W'(head_r[IDX_W-1:0]) * OFS_W'(size_r);

  assign sts.walk_last = (cnt_r == last_idx);
  assign sts.slot_free = !out_valid_r || out_ready;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r;
    wr_data = sts.walk_last ? NULL_LINK : (LINK_W'(cnt_r) + LINK_W'(1));
    if (cmd.walk) begin
      wr_en = 1'b1;
    end else if (cmd.take && in_mode == MODE_FREE && free_ok) begin
      wr_en   = 1'b1;
      wr_addr = in_block_index[AW-1:0];
      wr_data = head_r;
    end
  end

  // link memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (cmd.take) begin
      rd_r <= link_mem[head_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
      size_r  <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BLOCK_COUNT: count_r <= cfg_wdata[COUNT_W-1:0];
        REG_BLOCK_SIZE:  size_r  <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= NULL_LINK;
    end else if (cmd.take) begin
      if (in_mode == MODE_CREATE) begin
        head_r <= '0;
      end else if (in_mode == MODE_FREE && free_ok) begin
        head_r <= LINK_W'(in_block_index);
      end
    end else if (cmd.finish && mode_r == MODE_ALLOC) begin
      head_r <= empty ? NULL_LINK : rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mode_r <= in_mode;
      cnt_r  <= '0;
    end else if (cmd.walk) begin
      cnt_r <= cnt_r + AW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (mode_r == MODE_ALLOC && !empty) begin
        status_r <= STAT_ALLOC;
        index_r  <= head_r[IDX_W-1:0];
        offset_r <= product;
      end else begin
        status_r <= (mode_r == MODE_ALLOC) ? STAT_EMPTY : STAT_DONE;
        index_r  <= '0;
        offset_r <= '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_block_index_res = index_r;
  assign out_byte_offset     = offset_r;

endmodule

`default_nettype wire

@@ rtl/fixed_block_pool_allocator.sv @@
// top level of the fixed block pool allocator
// A pool of equal-sized blocks kept as a LIFO free list in a link memory of
// min(POOL_BLOCKS, 256) entries. Each request beat gives exactly one result
// beat. Allocate and free make one link memory access at accept, then load
// the result register; create and resize first walk the chain one link
// memory write a cycle over n links, n being block_count clamped to
// 1 .. min(POOL_BLOCKS, 256). One request is in work at a time; the result
// register lets a new request be taken while the last result still waits
// for out_ch.ready. The link memory has no reset and no clearing pass; of
// the free list state only the free head comes out of reset, as null (pool
// empty). The user is to write configuration (cfg_index 0 block_count, 1
// block_size) only while no request is in work; it is not enforced.
`default_nettype none

module fixed_block_pool_allocator import fbpa_pkg::*; #(
  parameter int POOL_BLOCKS = POOL_BLOCKS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  fbpa_in_if.sink                    in_ch,
  fbpa_out_if.source                 out_ch
);

  fbpa_cmd_t cmd;
  fbpa_sts_t sts;

  // sequencing of each request beat
  fbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // free list storage, offset multiply and result register
  fbpa_dpath #(
    .POOL_BLOCKS (POOL_BLOCKS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_mode             (in_ch.mode),
    .in_block_index      (in_ch.block_index),
    .in_block_present    (in_ch.block_present),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_status          (out_ch.status),
    .out_block_index_res (out_ch.block_index_res),
    .out_byte_offset     (out_ch.byte_offset)
  );

endmodule

`default_nettype wire

@@ rtl/fbpa_checker.sv @@
// port-level checks of the fixed block pool allocator and their bind
`default_nettype none

module fbpa_checker import fbpa_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [IDX_W-1:0]    out_index,
  input wire logic [OFS_W-1:0]    out_offset
);

  // a waiting result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_index) && $stable(out_offset))
    else $error("result beat dropped or changed while stalled");

  // one request in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_DONE || out_status == STAT_ALLOC
      || out_status == STAT_EMPTY))
    else $error("result status code out of range");

  // only an allocation carries a block
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_ALLOC |-> out_index == '0 && out_offset == '0)
    else $error("non-allocation result carries a block");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_index  (out_ch.block_index_res),
  .out_offset (out_ch.byte_offset)
);

`default_nettype wire
